// ===== hw/rtl/swing_down_stroke_detector_top_assert.svh =====
// assertion macros for the swing down-stroke detector top level
// depends on nothing; included by swing_down_stroke_detector_top.sv
`ifndef SWING_DOWN_STROKE_DETECTOR_TOP_ASSERT_SVH
`define SWING_DOWN_STROKE_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SDSD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sdsd assertion failed");

// next-cycle implication, checked outside reset
`define SDSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sdsd assertion failed");

`endif

// ===== hw/rtl/sdsd_pkg.sv =====
// shared types and constants of the swing down-stroke detector
// depends on nothing; used by sdsd_lane, sdsd_merge and the top level
package sdsd_pkg;

    localparam int CHANNELS   = 2;
    localparam int COORD_BITS = 10;
    localparam int STEP_BITS  = 10;
    localparam int JUMP_BITS  = 10;
    localparam int COOL_BITS  = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_MIN   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_JUMP_LIMIT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COOLDOWN   = 2'd2;

    localparam logic [STEP_BITS-1:0] STEP_MIN_RST   = 10'd15;
    localparam logic [JUMP_BITS-1:0] JUMP_LIMIT_RST = 10'd75;
    localparam logic [COOL_BITS-1:0] COOLDOWN_RST   = 8'd5;

    typedef struct packed {
        logic [STEP_BITS-1:0] step_min;
        logic [JUMP_BITS-1:0] jump_limit;
        logic [COOL_BITS-1:0] cooldown_frames;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  seen;
    } entry_t;

    typedef struct packed {
        logic                  hit;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } result_t;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== hw/rtl/sdsd_lane.sv =====
// one channel lane: two-entry history, strike test and cooldown counter
// depends on sdsd_pkg
module sdsd_lane
    import sdsd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    accept,
    input  cfg_t    cfg,
    input  entry_t  cur,
    output result_t res
);

    entry_t                old_reg, old_next;
    entry_t                mid_reg, mid_next;
    logic [COOL_BITS-1:0]  cnt_reg, cnt_next;

    logic                  jumps_ok;
    logic                  steps_ok;
    logic                  strike;
    logic [COOL_BITS-1:0]  cnt_dec;
    logic                  hit;
    logic signed [COORD_BITS+1:0] older_step;
    logic signed [COORD_BITS+1:0] newer_step;
    logic signed [COORD_BITS+1:0] step_min_s;

    always_comb begin
        jumps_ok = (abs_diff(old_reg.x, mid_reg.x) <= cfg.jump_limit)
                && (abs_diff(old_reg.y, mid_reg.y) <= cfg.jump_limit)
                && (abs_diff(mid_reg.x, cur.x) <= cfg.jump_limit)
                && (abs_diff(mid_reg.y, cur.y) <= cfg.jump_limit);
        older_step = $signed({2'b00, mid_reg.y}) - $signed({2'b00, old_reg.y});
        newer_step = $signed({2'b00, cur.y}) - $signed({2'b00, mid_reg.y});
        step_min_s = $signed({2'b00, cfg.step_min});
        steps_ok   = (older_step >= step_min_s) && (newer_step <= older_step);
        strike     = old_reg.seen && mid_reg.seen && cur.seen && jumps_ok && steps_ok;

        cnt_dec  = (cnt_reg != '0) ? cnt_reg - 1'b1 : cnt_reg;
        hit      = strike && (cnt_dec == '0);
        cnt_next = hit ? cfg.cooldown_frames : cnt_dec;

        old_next = mid_reg;
        mid_next = cur;

        res.hit = hit;
        res.x   = hit ? cur.x : '0;
        res.y   = hit ? cur.y : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            old_reg <= '0;
            mid_reg <= '0;
            cnt_reg <= '0;
        end else if (accept) begin
            old_reg <= old_next;
            mid_reg <= mid_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/sdsd_merge.sv =====
// merge stage: collects all lane results into one output register
// depends on sdsd_pkg
module sdsd_merge
    import sdsd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t lane_res [CHANNELS],
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res [CHANNELS]
);

    logic    valid_reg, valid_next;
    result_t res_reg [CHANNELS];
    logic    load;

    always_comb begin
        in_ready   = !valid_reg || out_ready;
        load       = in_valid && in_ready;
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= lane_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== hw/rtl/swing_down_stroke_detector_top.sv =====
// swing down-stroke detector top level: config registers, lanes, merge stage
// depends on sdsd_pkg, sdsd_lane, sdsd_merge and the assertion header
//
// usage:
//   input channel s_*: one request per video frame with x, y and seen for
//   channels a and b. output channel m_*: one result per request with the
//   hit flag and, on a hit, that frame's x and y (zero otherwise).
//   config channel cfg_*: index 0 step_min, 1 jump_limit, 2 cooldown_frames;
//   always ready, other indexes are ignored. write only while idle.
// output: the result is registered and valid in the cycle after the request is accepted.
// throughput: one request per cycle while m_ready takes each result; both
//   channels run in parallel lanes that each test one frame per cycle, and one
//   output register holds the merged result.
// stall: while a result waits on m_ready, s_ready drops; it rises again in
//   the cycle the result is taken, so a new request can enter at once.
// reset: history seen flags and cooldown counters clear, registers return
//   to 15, 75 and 5; no hit can fire before three frames have been taken.
`include "swing_down_stroke_detector_top_assert.svh"

module swing_down_stroke_detector_top
    import sdsd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [COORD_BITS-1:0]    s_pos_x_a,
    input  logic [COORD_BITS-1:0]    s_pos_y_a,
    input  logic                     s_seen_a,
    input  logic [COORD_BITS-1:0]    s_pos_x_b,
    input  logic [COORD_BITS-1:0]    s_pos_y_b,
    input  logic                     s_seen_b,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_hit_a,
    output logic [COORD_BITS-1:0]    m_hit_x_a,
    output logic [COORD_BITS-1:0]    m_hit_y_a,
    output logic                     m_hit_b,
    output logic [COORD_BITS-1:0]    m_hit_x_b,
    output logic [COORD_BITS-1:0]    m_hit_y_b,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    entry_t  lane_in  [CHANNELS];
    result_t lane_res [CHANNELS];
    result_t out_res  [CHANNELS];
    logic    accept;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_STEP_MIN:   cfg_next.step_min        = cfg_data[STEP_BITS-1:0];
                CFG_JUMP_LIMIT: cfg_next.jump_limit      = cfg_data[JUMP_BITS-1:0];
                CFG_COOLDOWN:   cfg_next.cooldown_frames = cfg_data[COOL_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_min        <= STEP_MIN_RST;
            cfg_reg.jump_limit      <= JUMP_LIMIT_RST;
            cfg_reg.cooldown_frames <= COOLDOWN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        lane_in[0] = '{x: s_pos_x_a, y: s_pos_y_a, seen: s_seen_a};
        lane_in[1] = '{x: s_pos_x_b, y: s_pos_y_b, seen: s_seen_b};
    end

    assign accept = s_valid && s_ready;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        sdsd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .accept  (accept),
            .cfg     (cfg_reg),
            .cur     (lane_in[c]),
            .res     (lane_res[c])
        );
    end

    sdsd_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .lane_res  (lane_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_hit_a   = out_res[0].hit;
    assign m_hit_x_a = out_res[0].x;
    assign m_hit_y_a = out_res[0].y;
    assign m_hit_b   = out_res[1].hit;
    assign m_hit_x_b = out_res[1].x;
    assign m_hit_y_b = out_res[1].y;

    `SDSD_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, s_valid && s_ready, m_valid)
    `SDSD_ASSERT_NEXT(a_drain_empties, aclk, aresetn, m_valid && m_ready && !s_valid, !m_valid)
    `SDSD_ASSERT_NOW(a_stall_only_when_full, aclk, aresetn, !s_ready, m_valid && !m_ready)
    `SDSD_ASSERT_NOW(a_no_hit_zero_pos, aclk, aresetn, m_valid && !m_hit_a, m_hit_x_a == '0 && m_hit_y_a == '0)

endmodule
